// File: hdl/rmap_pkg.sv
// shared types and constants for the transaction id remap table
`timescale 1ns / 1ps

package rmap_pkg;

   localparam int ID_W      = 16;
   localparam int IP_W      = 32;
   localparam int PORT_W    = 16;
   localparam int STAMP_W   = 32;
   localparam int TIMEOUT_W = 16;
   localparam int COUNT_W   = 7;
   localparam int STATUS_W  = 3;
   localparam int REQ_W     = 2;

   localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RESOLVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TICK_DONE = 3'd4;

   localparam logic [ID_W-1:0]      FIRST_FORWARD_ID = 16'h8000;
   localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT  = 16'd30;
   localparam logic [COUNT_W-1:0]   COUNT_MAX        = 7'd127;

   typedef struct packed {
      logic [ID_W-1:0]    orig_id;
      logic [ID_W-1:0]    fwd_id;
      logic [IP_W-1:0]    client_ip;
      logic [PORT_W-1:0]  client_port;
      logic [STAMP_W-1:0] stamp;
   } slot_entry_type;

   localparam int ENTRY_W = $bits(slot_entry_type);

   typedef struct packed {
      logic               live;
      logic               is_tick;
      logic               slot_valid;
      logic [ID_W-1:0]    lookup_id;
      logic [STAMP_W-1:0] now_seconds;
   } cmp_ctl_type;

endpackage

// File: hdl/rmap_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rmap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rmap_match_unit.sv
// shared slot compare unit: forward id match or age expiry test
`timescale 1ns / 1ps

module rmap_match_unit (
   input  rmap_pkg::cmp_ctl_type                ctl,
   input  rmap_pkg::slot_entry_type             entry,
   input  logic [rmap_pkg::TIMEOUT_W-1:0]       timeout,
   output logic                                 hit
);

   logic [rmap_pkg::STAMP_W-1:0] age;
   logic                         cond;

   always_comb begin
      age = ctl.now_seconds - entry.stamp;
      if (ctl.is_tick) begin
         cond = age > {{(rmap_pkg::STAMP_W - rmap_pkg::TIMEOUT_W){1'b0}}, timeout};
      end else begin
         cond = entry.fwd_id == ctl.lookup_id;
      end
      hit = ctl.live && ctl.slot_valid && cond;
   end

endmodule

// File: hdl/rmap_ctrl.sv
// sequencer: slot valid bits, id and time counters, slot scan and result register
`timescale 1ns / 1ps

module rmap_ctrl #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [rmap_pkg::REQ_W-1:0]             req_type,
   input  logic [rmap_pkg::ID_W-1:0]              req_client_id,
   input  logic [rmap_pkg::IP_W-1:0]              req_client_ip,
   input  logic [rmap_pkg::PORT_W-1:0]            req_client_port,
   input  logic [rmap_pkg::ID_W-1:0]              req_lookup_id,
   output logic                                   rsp_strobe,
   output logic [rmap_pkg::STATUS_W-1:0]          rsp_status,
   output logic [rmap_pkg::ID_W-1:0]              rsp_id_out,
   output logic [rmap_pkg::IP_W-1:0]              rsp_ip_out,
   output logic [rmap_pkg::PORT_W-1:0]            rsp_port_out,
   output logic [rmap_pkg::COUNT_W-1:0]           rsp_expired_count,
   output logic                                   ram_wr_en,
   output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] ram_wr_addr,
   output rmap_pkg::slot_entry_type               ram_wr_data,
   output logic                                   ram_rd_en,
   output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1)-1:0] ram_rd_addr,
   input  rmap_pkg::slot_entry_type               ram_rd_data,
   output rmap_pkg::cmp_ctl_type                  cmp_ctl,
   input  logic                                   cmp_hit
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic                            op_tick_ff, op_tick_in;
   logic [rmap_pkg::ID_W-1:0]       cid_ff, cid_in;
   logic [rmap_pkg::IP_W-1:0]       cip_ff, cip_in;
   logic [rmap_pkg::PORT_W-1:0]     cport_ff, cport_in;
   logic [rmap_pkg::ID_W-1:0]       look_ff, look_in;
   logic [TABLE_SLOTS-1:0]          valid_ff, valid_in;
   logic [rmap_pkg::ID_W-1:0]       next_id_ff, next_id_in;
   logic [rmap_pkg::STAMP_W-1:0]    now_ff, now_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            issue_live_ff, issue_live_in;
   logic [IDX_W-1:0]                cmp_idx_ff, cmp_idx_in;
   logic                            cmp_live_ff, cmp_live_in;
   logic [rmap_pkg::COUNT_W-1:0]    freed_ff, freed_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic [rmap_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [rmap_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [rmap_pkg::IP_W-1:0]       rsp_ip_ff, rsp_ip_in;
   logic [rmap_pkg::PORT_W-1:0]     rsp_port_ff, rsp_port_in;
   logic [rmap_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [rmap_pkg::COUNT_W-1:0]    freed_nxt;

   always_comb begin
      state_in      = state_ff;
      op_tick_in    = op_tick_ff;
      cid_in        = cid_ff;
      cip_in        = cip_ff;
      cport_in      = cport_ff;
      look_in       = look_ff;
      valid_in      = valid_ff;
      next_id_in    = next_id_ff;
      now_in        = now_ff;
      idx_in        = idx_ff;
      issue_live_in = issue_live_ff;
      cmp_idx_in    = cmp_idx_ff;
      cmp_live_in   = cmp_live_ff;
      freed_in      = freed_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_ip_in     = rsp_ip_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      freed_nxt     = freed_ff;
      if (cmp_hit && (freed_ff < rmap_pkg::COUNT_MAX)) begin
         freed_nxt = freed_ff + 7'd1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cid_in        = req_client_id;
               cip_in        = req_client_ip;
               cport_in      = req_client_port;
               look_in       = req_lookup_id;
               idx_in        = '0;
               issue_live_in = 1'b1;
               cmp_live_in   = 1'b0;
               freed_in      = '0;
               unique case (req_type)
                  rmap_pkg::REQ_ALLOC: begin
                     state_in = ST_ALLOC;
                  end
                  rmap_pkg::REQ_RESOLVE: begin
                     state_in   = ST_SCAN;
                     op_tick_in = 1'b0;
                  end
                  rmap_pkg::REQ_TICK: begin
                     state_in   = ST_SCAN;
                     op_tick_in = 1'b1;
                     now_in     = now_ff + 32'd1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            if (!valid_ff[idx_ff]) begin
               ram_wr_en        = 1'b1;
               valid_in[idx_ff] = 1'b1;
               next_id_in       = next_id_ff + 16'd1;
               rsp_strobe_in    = 1'b1;
               rsp_status_in    = rmap_pkg::STATUS_ALLOCATED;
               rsp_id_in        = next_id_ff;
               rsp_ip_in        = '0;
               rsp_port_in      = '0;
               rsp_count_in     = '0;
               state_in         = ST_IDLE;
            end else if (idx_ff == LAST_IDX) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = rmap_pkg::STATUS_FULL;
               rsp_id_in     = cid_ff;
               rsp_ip_in     = '0;
               rsp_port_in   = '0;
               rsp_count_in  = '0;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            ram_rd_en   = issue_live_ff;
            cmp_live_in = issue_live_ff;
            cmp_idx_in  = idx_ff;
            if (issue_live_ff) begin
               if (idx_ff == LAST_IDX) begin
                  issue_live_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (cmp_live_ff) begin
               if (cmp_hit) begin
                  valid_in[cmp_idx_ff] = 1'b0;
               end
               freed_in = freed_nxt;
               if (cmp_hit && !op_tick_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rmap_pkg::STATUS_FOUND;
                  rsp_id_in     = ram_rd_data.orig_id;
                  rsp_ip_in     = ram_rd_data.client_ip;
                  rsp_port_in   = ram_rd_data.client_port;
                  rsp_count_in  = '0;
                  state_in      = ST_IDLE;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  rsp_strobe_in = 1'b1;
                  rsp_id_in     = '0;
                  rsp_ip_in     = '0;
                  rsp_port_in   = '0;
                  if (op_tick_ff) begin
                     rsp_status_in = rmap_pkg::STATUS_TICK_DONE;
                     rsp_count_in  = freed_nxt;
                  end else begin
                     rsp_status_in = rmap_pkg::STATUS_NOT_FOUND;
                     rsp_count_in  = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_tick_ff    <= 1'b0;
         valid_ff      <= '0;
         next_id_ff    <= rmap_pkg::FIRST_FORWARD_ID;
         now_ff        <= '0;
         idx_ff        <= '0;
         issue_live_ff <= 1'b0;
         cmp_idx_ff    <= '0;
         cmp_live_ff   <= 1'b0;
         freed_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_tick_ff    <= op_tick_in;
         valid_ff      <= valid_in;
         next_id_ff    <= next_id_in;
         now_ff        <= now_in;
         idx_ff        <= idx_in;
         issue_live_ff <= issue_live_in;
         cmp_idx_ff    <= cmp_idx_in;
         cmp_live_ff   <= cmp_live_in;
         freed_ff      <= freed_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cid_ff        <= cid_in;
      cip_ff        <= cip_in;
      cport_ff      <= cport_in;
      look_ff       <= look_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_ip_ff     <= rsp_ip_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_id_out        = rsp_id_ff;
   assign rsp_ip_out        = rsp_ip_ff;
   assign rsp_port_out      = rsp_port_ff;
   assign rsp_expired_count = rsp_count_ff;

   assign ram_wr_addr = idx_ff;
   assign ram_rd_addr = idx_ff;
   assign ram_wr_data = '{orig_id:     cid_ff,
                          fwd_id:      next_id_ff,
                          client_ip:   cip_ff,
                          client_port: cport_ff,
                          stamp:       now_ff};

   assign cmp_ctl = '{live:        cmp_live_ff && (state_ff == ST_SCAN),
                      is_tick:     op_tick_ff,
                      slot_valid:  valid_ff[cmp_idx_ff],
                      lookup_id:   look_ff,
                      now_seconds: now_ff};

endmodule

// File: hdl/transaction_id_remap_table.sv
// top level of the transaction id remap table
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; busy then stays high until
// its result appears on the rsp_ ports for exactly one cycle with rsp_strobe high. The
// receiver cannot stall the result. The table is walked one slot per clock through a
// single write port entry ram and one shared compare unit: an allocate takes the first
// free slot or reports full after the last slot, a resolve stops at the first matching
// slot or after the last one, and a tick always scans every slot. busy is low again in
// the cycle the result is shown, so the next transaction can be taken then. Request
// type 3 is taken and ignored with no result. Slot valid bits clear at reset, so no
// clearing pass is needed. csr_wr_data sets the expiry timeout in seconds (reset value
// 30) and must be written only while the block is idle; the block does not enforce it.
module transaction_id_remap_table #(
   parameter int TABLE_SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rmap_pkg::REQ_W-1:0]          req_type,
   input  logic [rmap_pkg::ID_W-1:0]           req_client_id,
   input  logic [rmap_pkg::IP_W-1:0]           req_client_ip,
   input  logic [rmap_pkg::PORT_W-1:0]         req_client_port,
   input  logic [rmap_pkg::ID_W-1:0]           req_lookup_id,
   output logic                                rsp_strobe,
   output logic [rmap_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rmap_pkg::ID_W-1:0]           rsp_id_out,
   output logic [rmap_pkg::IP_W-1:0]           rsp_ip_out,
   output logic [rmap_pkg::PORT_W-1:0]         rsp_port_out,
   output logic [rmap_pkg::COUNT_W-1:0]        rsp_expired_count,
   input  logic                                csr_wr_en,
   input  logic [rmap_pkg::TIMEOUT_W-1:0]      csr_wr_data
);

   localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   logic [rmap_pkg::TIMEOUT_W-1:0] timeout_ff;

   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   rmap_pkg::slot_entry_type      ram_wr_entry;
   logic                          ram_rd_en;
   logic [IDX_W-1:0]              ram_rd_addr;
   logic [rmap_pkg::ENTRY_W-1:0]  ram_rd_bits;
   rmap_pkg::slot_entry_type      ram_rd_entry;
   rmap_pkg::cmp_ctl_type         cmp_ctl;
   logic                          cmp_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= rmap_pkg::DEFAULT_TIMEOUT;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   assign ram_rd_entry = rmap_pkg::slot_entry_type'(ram_rd_bits);

   rmap_ctrl #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_client_id     (req_client_id),
      .req_client_ip     (req_client_ip),
      .req_client_port   (req_client_port),
      .req_lookup_id     (req_lookup_id),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_id_out        (rsp_id_out),
      .rsp_ip_out        (rsp_ip_out),
      .rsp_port_out      (rsp_port_out),
      .rsp_expired_count (rsp_expired_count),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_entry),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_entry),
      .cmp_ctl           (cmp_ctl),
      .cmp_hit           (cmp_hit)
   );

   rmap_ram #(
      .WIDTH(rmap_pkg::ENTRY_W),
      .DEPTH(TABLE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   rmap_match_unit u_match (
      .ctl     (cmp_ctl),
      .entry   (ram_rd_entry),
      .timeout (timeout_ff),
      .hit     (cmp_hit)
   );

endmodule

// File: hdl/rmap_checker.sv
// port level checks for the transaction id remap table, bound to the top level
`timescale 1ns / 1ps

module rmap_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [rmap_pkg::REQ_W-1:0]          req_type,
   input logic                                rsp_strobe,
   input logic [rmap_pkg::STATUS_W-1:0]       rsp_status,
   input logic [rmap_pkg::IP_W-1:0]           rsp_ip_out,
   input logic [rmap_pkg::PORT_W-1:0]         rsp_port_out,
   input logic [rmap_pkg::COUNT_W-1:0]        rsp_expired_count
);

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high in two adjacent cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_type == rmap_pkg::REQ_ALLOC ||
                          req_type == rmap_pkg::REQ_RESOLVE ||
                          req_type == rmap_pkg::REQ_TICK)) |=> busy)
      else $error("busy not raised after a transaction was taken");

   a_result_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy still high while a result is shown");

   a_unused_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == rmap_pkg::REQ_UNUSED) |=> (!busy && !rsp_strobe))
      else $error("unused request type caused activity");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != rmap_pkg::STATUS_FOUND) |->
         (rsp_ip_out == '0 && rsp_port_out == '0 &&
          (rsp_status == rmap_pkg::STATUS_TICK_DONE || rsp_expired_count == '0)))
      else $error("result field not zero for this status");

endmodule

bind transaction_id_remap_table rmap_checker u_rmap_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_type          (req_type),
   .rsp_strobe        (rsp_strobe),
   .rsp_status        (rsp_status),
   .rsp_ip_out        (rsp_ip_out),
   .rsp_port_out      (rsp_port_out),
   .rsp_expired_count (rsp_expired_count)
);

// File: dv/tb_transaction_id_remap_table.sv
// self-checking testbench for the transaction id remap table
`timescale 1ns / 1ps

module tb_transaction_id_remap_table;

   localparam int SLOTS          = 64;
   localparam int SETTLE_CYCLES  = SLOTS + 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_ITEMS    = 130;

   typedef struct packed {
      logic [rmap_pkg::REQ_W-1:0]  kind;
      logic [rmap_pkg::ID_W-1:0]   orig_id;
      logic [rmap_pkg::IP_W-1:0]   client_ip;
      logic [rmap_pkg::PORT_W-1:0] client_port;
      logic [rmap_pkg::ID_W-1:0]   lookup_id;
   } remap_req_type;

   typedef struct packed {
      logic [rmap_pkg::STATUS_W-1:0] status;
      logic [rmap_pkg::ID_W-1:0]     id;
      logic [rmap_pkg::IP_W-1:0]     ip;
      logic [rmap_pkg::PORT_W-1:0]   port;
      logic [rmap_pkg::COUNT_W-1:0]  expired;
   } remap_rsp_type;

   typedef struct packed {
      bit                             is_cfg;
      logic [rmap_pkg::TIMEOUT_W-1:0] timeout;
      remap_req_type                  req;
      bit                             typed;
      remap_rsp_type                  rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rmap_pkg::REQ_W-1:0]     req_type = '0;
   logic [rmap_pkg::ID_W-1:0]      req_client_id = '0;
   logic [rmap_pkg::IP_W-1:0]      req_client_ip = '0;
   logic [rmap_pkg::PORT_W-1:0]    req_client_port = '0;
   logic [rmap_pkg::ID_W-1:0]      req_lookup_id = '0;
   logic                           rsp_strobe;
   logic [rmap_pkg::STATUS_W-1:0]  rsp_status;
   logic [rmap_pkg::ID_W-1:0]      rsp_id_out;
   logic [rmap_pkg::IP_W-1:0]      rsp_ip_out;
   logic [rmap_pkg::PORT_W-1:0]    rsp_port_out;
   logic [rmap_pkg::COUNT_W-1:0]   rsp_expired_count;
   logic                           csr_wr_en = 1'b0;
   logic [rmap_pkg::TIMEOUT_W-1:0] csr_wr_data = '0;

   // mirror of the mapping table
   bit                             tbl_valid [SLOTS];
   logic [rmap_pkg::ID_W-1:0]      tbl_orig_id [SLOTS];
   logic [rmap_pkg::ID_W-1:0]      tbl_fwd_id [SLOTS];
   logic [rmap_pkg::IP_W-1:0]      tbl_ip [SLOTS];
   logic [rmap_pkg::PORT_W-1:0]    tbl_port [SLOTS];
   logic [rmap_pkg::STAMP_W-1:0]   tbl_stamp [SLOTS];
   logic [rmap_pkg::ID_W-1:0]      next_fwd_id = rmap_pkg::FIRST_FORWARD_ID;
   logic [rmap_pkg::STAMP_W-1:0]   seconds_now = '0;
   logic [rmap_pkg::TIMEOUT_W-1:0] timeout_cfg = rmap_pkg::DEFAULT_TIMEOUT;

   remap_rsp_type pending_rsp_q[$];
   stim_row_type  directed_rows[$];
   int            mismatch_count = 0;

   always #4 clock = ~clock;

   transaction_id_remap_table #(
      .TABLE_SLOTS(SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_client_id(req_client_id),
      .req_client_ip(req_client_ip),
      .req_client_port(req_client_port),
      .req_lookup_id(req_lookup_id),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_id_out(rsp_id_out),
      .rsp_ip_out(rsp_ip_out),
      .rsp_port_out(rsp_port_out),
      .rsp_expired_count(rsp_expired_count),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   function automatic bit predict_remap(input remap_req_type r, output remap_rsp_type p);
      int slot;
      int unsigned freed;
      logic [rmap_pkg::STAMP_W-1:0] age;
      bit has_rsp;
      p = '0;
      has_rsp = 1'b1;
      slot = -1;
      freed = 0;
      case (r.kind)
         rmap_pkg::REQ_ALLOC: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && !tbl_valid[i]) slot = i;
            if (slot < 0) begin
               p.status = rmap_pkg::STATUS_FULL;
               p.id = r.orig_id;
            end else begin
               tbl_valid[slot] = 1'b1;
               tbl_orig_id[slot] = r.orig_id;
               tbl_fwd_id[slot] = next_fwd_id;
               tbl_ip[slot] = r.client_ip;
               tbl_port[slot] = r.client_port;
               tbl_stamp[slot] = seconds_now;
               p.status = rmap_pkg::STATUS_ALLOCATED;
               p.id = next_fwd_id;
               next_fwd_id = next_fwd_id + 1'b1;
            end
         end
         rmap_pkg::REQ_RESOLVE: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && tbl_valid[i] && tbl_fwd_id[i] == r.lookup_id) slot = i;
            if (slot < 0) begin
               p.status = rmap_pkg::STATUS_NOT_FOUND;
            end else begin
               tbl_valid[slot] = 1'b0;
               p.status = rmap_pkg::STATUS_FOUND;
               p.id = tbl_orig_id[slot];
               p.ip = tbl_ip[slot];
               p.port = tbl_port[slot];
            end
         end
         rmap_pkg::REQ_TICK: begin
            seconds_now = seconds_now + 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
               age = seconds_now - tbl_stamp[i];
               if (tbl_valid[i] && age > {16'b0, timeout_cfg}) begin
                  tbl_valid[i] = 1'b0;
                  if (freed < rmap_pkg::COUNT_MAX) freed++;
               end
            end
            p.status = rmap_pkg::STATUS_TICK_DONE;
            p.expired = freed[rmap_pkg::COUNT_W-1:0];
         end
         default: has_rsp = 1'b0;
      endcase
      return has_rsp;
   endfunction

   function automatic logic [rmap_pkg::ID_W-1:0] pick_lookup();
      int live[$];
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i]) live.push_back(i);
      if (live.size() == 0) return rmap_pkg::ID_W'($urandom());
      return tbl_fwd_id[live[$urandom_range(0, live.size() - 1)]];
   endfunction

   function automatic remap_req_type random_req(input int unsigned w_alloc,
                                                input int unsigned w_resolve,
                                                input int unsigned w_tick);
      remap_req_type r;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < w_alloc) r.kind = rmap_pkg::REQ_ALLOC;
      else if (roll < w_alloc + w_resolve) r.kind = rmap_pkg::REQ_RESOLVE;
      else if (roll < w_alloc + w_resolve + w_tick) r.kind = rmap_pkg::REQ_TICK;
      else r.kind = rmap_pkg::REQ_UNUSED;
      r.orig_id = rmap_pkg::ID_W'($urandom());
      r.client_ip = $urandom();
      r.client_port = rmap_pkg::PORT_W'($urandom());
      r.lookup_id = rmap_pkg::ID_W'($urandom());
      if (r.kind == rmap_pkg::REQ_RESOLVE && $urandom_range(0, 4) != 0)
         r.lookup_id = pick_lookup();
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
      mismatch_count++;
   endtask

   task automatic add_cfg(input logic [rmap_pkg::TIMEOUT_W-1:0] tmo);
      stim_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.timeout = tmo;
      directed_rows.push_back(row);
   endtask

   task automatic add_txn(input logic [rmap_pkg::REQ_W-1:0] kind,
                          input logic [rmap_pkg::ID_W-1:0] cid,
                          input logic [rmap_pkg::IP_W-1:0] cip,
                          input logic [rmap_pkg::PORT_W-1:0] cport,
                          input logic [rmap_pkg::ID_W-1:0] look, input bit typed,
                          input logic [rmap_pkg::STATUS_W-1:0] st,
                          input logic [rmap_pkg::ID_W-1:0] id,
                          input logic [rmap_pkg::IP_W-1:0] ip,
                          input logic [rmap_pkg::PORT_W-1:0] port,
                          input logic [rmap_pkg::COUNT_W-1:0] cnt);
      stim_row_type row;
      row = '0;
      row.req = {kind, cid, cip, cport, look};
      row.typed = typed;
      row.rsp = {st, id, ip, port, cnt};
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input remap_req_type r, input bit typed,
                            input remap_rsp_type typed_rsp, output remap_rsp_type pred);
      req_type <= r.kind;
      req_client_id <= r.orig_id;
      req_client_ip <= r.client_ip;
      req_client_port <= r.client_port;
      req_lookup_id <= r.lookup_id;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (predict_remap(r, pred)) pending_rsp_q.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   task automatic write_timeout(input logic [rmap_pkg::TIMEOUT_W-1:0] tmo);
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= tmo;
      @(posedge clock);
      timeout_cfg = tmo;
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin : check_rsp
      remap_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("result with no transaction pending, status", '0,
                            32'(rsp_status));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_id_out !== want.id)
               report_mismatch("id_out", 32'(want.id), 32'(rsp_id_out));
            if (rsp_ip_out !== want.ip) report_mismatch("ip_out", want.ip, rsp_ip_out);
            if (rsp_port_out !== want.port)
               report_mismatch("port_out", 32'(want.port), 32'(rsp_port_out));
            if (rsp_expired_count !== want.expired)
               report_mismatch("expired_count", 32'(want.expired), 32'(rsp_expired_count));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || rsp_strobe || (start && !busy)) quiet = 0;
         else quiet++;
      end
      $display("transaction_id_remap_table verification failed");
      $finish;
   end

   initial begin : stimulus
      remap_rsp_type pred;
      remap_req_type r;
      logic [rmap_pkg::ID_W-1:0] live_ids[$];
      logic [rmap_pkg::TIMEOUT_W-1:0] tmo;
      int unsigned w_alloc, w_resolve, w_tick;
      int stretch_left;
      bit idling;

      // reset timeout first, then the boundary of expiry at zero and one
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, rmap_pkg::FIRST_FORWARD_ID, 1'b1,
              rmap_pkg::STATUS_NOT_FOUND, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b1,
              rmap_pkg::STATUS_TICK_DONE, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_ALLOC, 16'h0000, 32'h0, 16'h0000, 16'h0, 1'b1,
              rmap_pkg::STATUS_ALLOCATED, 16'h8000, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              rmap_pkg::STATUS_ALLOCATED, 16'h8001, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_ALLOC, 16'h1234, 32'hC0A8_0001, 16'h0035, 16'h0, 1'b1,
              rmap_pkg::STATUS_ALLOCATED, 16'h8002, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'h8001, 1'b1,
              rmap_pkg::STATUS_FOUND, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'h8001, 1'b1,
              rmap_pkg::STATUS_NOT_FOUND, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_ALLOC, 16'hA5A5, 32'h5A5A_5A5A, 16'h5A5A, 16'h0, 1'b1,
              rmap_pkg::STATUS_ALLOCATED, 16'h8003, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'h8000, 1'b1,
              rmap_pkg::STATUS_FOUND, 16'h0000, 32'h0, 16'h0000, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'hFFFF, 1'b1,
              rmap_pkg::STATUS_NOT_FOUND, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'h0000, 1'b1,
              rmap_pkg::STATUS_NOT_FOUND, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_cfg(16'h0000);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_RESOLVE, 16'h0, 32'h0, 16'h0, 16'h8002, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_cfg(16'h0001);
      add_txn(rmap_pkg::REQ_ALLOC, 16'h0F0F, 32'h0A00_0001, 16'hF0F0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_cfg(16'hFFFF);
      add_txn(rmap_pkg::REQ_ALLOC, 16'h7777, 32'h7F00_0001, 16'h1F90, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);
      add_txn(rmap_pkg::REQ_TICK, 16'h0, 32'h0, 16'h0, 16'h0, 1'b0,
              '0, 16'h0, 32'h0, 16'h0, 7'd0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         if (directed_rows[n].is_cfg) write_timeout(directed_rows[n].timeout);
         else send_item(directed_rows[n].req, directed_rows[n].typed,
                        directed_rows[n].rsp, pred);
      end

      // random phases, each setting a timeout and a mix of requests
      idling = 1'b0;
      stretch_left = 0;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin tmo = 16'hFFFF; w_alloc = 70; w_resolve = 20; w_tick = 5; end
            1: begin tmo = 16'h0000; w_alloc = 40; w_resolve = 30; w_tick = 25; end
            2: begin
               tmo = rmap_pkg::TIMEOUT_W'($urandom_range(1, 8));
               w_alloc = 40; w_resolve = 30; w_tick = 25;
            end
            3: begin
               tmo = rmap_pkg::DEFAULT_TIMEOUT; w_alloc = 45; w_resolve = 35; w_tick = 15;
            end
            default: begin
               tmo = rmap_pkg::TIMEOUT_W'($urandom_range(0, 65535));
               w_alloc = 40; w_resolve = 35; w_tick = 20;
            end
         endcase
         write_timeout(tmo);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (stretch_left == 0) begin
               idling = $urandom_range(0, 1);
               stretch_left = $urandom_range(10, 40);
            end
            stretch_left--;
            if (ph == 1 && k == PHASE_ITEMS / 2) wait_results();
            r = random_req(w_alloc, w_resolve, w_tick);
            send_item(r, 1'b0, '0, pred);
            if (idling && $urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 5));
         end
      end

      // empty the table back to back
      wait_results();
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i]) live_ids.push_back(tbl_fwd_id[i]);
      foreach (live_ids[n]) begin
         r = '0;
         r.kind = rmap_pkg::REQ_RESOLVE;
         r.lookup_id = live_ids[n];
         send_item(r, 1'b0, '0, pred);
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("transaction_id_remap_table verification clean");
      end else begin
         $display("transaction_id_remap_table verification failed");
      end
      $finish;
   end

endmodule
